@@ sv/ile_pkg.sv @@
// Shared types and constants of the indexed list engine.
`timescale 1ns / 1ps
package ile_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int POS_W      = 5;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        MODE_APPEND     = 3'd0,
        MODE_INSERT     = 3'd1,
        MODE_REMOVE_AT  = 3'd2,
        MODE_REMOVE_VAL = 3'd3,
        MODE_GET        = 3'd4,
        MODE_POP_FIRST  = 3'd5,
        MODE_POP_LAST   = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] size;
    } t_entry;

    typedef enum logic [2:0] {
        SH_HOLD,
        SH_LOAD_AT,
        SH_INSERT,
        SH_REMOVE,
        SH_REMOVE_MATCH
    } t_shift_op;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic             sample;
        t_shift_op        op;
        logic [IDX_W-1:0] at;
        logic [CNT_W-1:0] count;
    } t_cell_ctl;

endpackage

@@ sv/ile_if.sv @@
// Valid/ready channels for list commands and list responses.
`timescale 1ns / 1ps
interface ile_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [4:0]  position;
    logic [31:0] entry_value;
    logic [15:0] entry_size;

    modport source (output valid, mode, position, entry_value, entry_size, input ready);
    modport sink   (input valid, mode, position, entry_value, entry_size, output ready);
endinterface

interface ile_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_value;
    logic [15:0] out_size;
    logic [4:0]  list_length;

    modport source (output valid, status, out_value, out_size, list_length, input ready);
    modport sink   (input valid, status, out_value, out_size, list_length, output ready);
endinterface

@@ sv/ile_cell.sv @@
// One list slot: holds an entry and shifts it to or from its neighbors.
`timescale 1ns / 1ps
module ile_cell (
    input  logic                    i_clk,
    input  logic [ile_pkg::IDX_W-1:0] i_idx,
    input  ile_pkg::t_cell_ctl      i_ctl,
    input  ile_pkg::t_entry         i_new,
    input  ile_pkg::t_entry         i_prev,
    input  ile_pkg::t_entry         i_next,
    input  logic                    i_seen,
    output logic                    o_seen,
    output ile_pkg::t_entry         o_entry
);
    import ile_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   r_match;
    logic   w_live;

    assign w_live  = CNT_W'(i_idx) < i_ctl.count;
    // A match here or anywhere to the left pulls this slot from its right neighbor.
    assign o_seen  = i_seen | r_match;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            SH_LOAD_AT: begin
                if (i_idx == i_ctl.at) n_entry = i_new;
            end
            SH_INSERT: begin
                if (i_idx == i_ctl.at) n_entry = i_new;
                else if (i_idx > i_ctl.at) n_entry = i_prev;
            end
            SH_REMOVE: begin
                if (i_idx >= i_ctl.at) n_entry = i_next;
            end
            SH_REMOVE_MATCH: begin
                if (o_seen) n_entry = i_next;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.sample) r_match <= w_live && (r_entry.value == i_new.value);
    end

endmodule

@@ sv/indexed_list_engine_top.sv @@
// Top level of the indexed list engine: controller and chain of list cells.
`timescale 1ns / 1ps
// Ordered list of LIST_DEPTH entries (32-bit handle, 16-bit size tag), packed
// from index 0, held in a chain of cells that shift toward or away from a gap.
// Each command passes through a compare/read cycle, in which every cell checks
// its handle against the command's value and the addressed entry is registered,
// then an apply cycle in which the chain shifts and the response is loaded. A
// new command is taken during the apply cycle, so the engine accepts the next
// command before the last one is through while the response side keeps up; a
// stalled response holds the controller in its apply cycle. Entries start
// undefined and only entries below the length ever reach the response.
module indexed_list_engine_top (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ile_cmd_if.sink   i_cmd,
    ile_rsp_if.source o_rsp
);
    import ile_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [2:0]        r_mode;
    logic [POS_W-1:0]  r_pos;
    t_entry            r_new;
    t_entry            r_rd;
    logic              r_out_valid;
    t_status           r_status, n_status;
    t_entry            r_out, n_out;
    logic [4:0]        r_out_len;

    t_cell_ctl         w_ctl;
    t_shift_op         w_op;
    logic [IDX_W-1:0]  w_at;
    logic [IDX_W-1:0]  w_rd_idx;
    t_entry            w_cells [LIST_DEPTH];
    logic              w_seen  [LIST_DEPTH+1];
    logic              w_can_load, w_apply, w_accept, w_full;
    logic [CMP_W-1:0]  w_pos_x, w_cnt_x;

    assign w_can_load = !r_out_valid || o_rsp.ready;
    assign w_apply    = (r_state == S_APPLY) && w_can_load;
    assign i_cmd.ready = (r_state == S_IDLE) || w_apply;
    assign w_accept   = i_cmd.valid && i_cmd.ready;

    assign w_full  = r_count >= CNT_W'(LIST_DEPTH);
    assign w_pos_x = CMP_W'(r_pos);
    assign w_cnt_x = CMP_W'(r_count);

    // Decide status, chain shift and new length from the latched command.
    always_comb begin
        n_status = STAT_OK;
        n_out    = '0;
        n_count  = r_count;
        w_op     = SH_HOLD;
        w_at     = '0;
        case (r_mode)
            MODE_APPEND: begin
                if (w_full) n_status = STAT_FULL;
                else begin
                    w_op    = SH_LOAD_AT;
                    w_at    = IDX_W'(r_count);
                    n_count = r_count + 1'b1;
                end
            end
            MODE_INSERT: begin
                if (w_pos_x > w_cnt_x) n_status = STAT_RANGE;
                else if (w_full) n_status = STAT_FULL;
                else begin
                    w_op    = SH_INSERT;
                    w_at    = IDX_W'(r_pos);
                    n_count = r_count + 1'b1;
                end
            end
            MODE_REMOVE_AT: begin
                if (w_pos_x >= w_cnt_x) n_status = STAT_RANGE;
                else begin
                    w_op    = SH_REMOVE;
                    w_at    = IDX_W'(r_pos);
                    n_count = r_count - 1'b1;
                end
            end
            MODE_REMOVE_VAL: begin
                w_op = SH_REMOVE_MATCH;
                if (w_seen[LIST_DEPTH]) n_count = r_count - 1'b1;
            end
            MODE_GET: begin
                if (w_pos_x >= w_cnt_x) n_status = STAT_RANGE;
                else n_out = r_rd;
            end
            MODE_POP_FIRST: begin
                if (r_count == '0) n_status = STAT_EMPTY;
                else begin
                    n_out   = r_rd;
                    w_op    = SH_REMOVE;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_POP_LAST: begin
                if (r_count == '0) n_status = STAT_EMPTY;
                else begin
                    n_out   = r_rd;
                    n_count = r_count - 1'b1;
                end
            end
            default: n_status = STAT_OK;
        endcase
    end

    always_comb begin
        case (r_mode)
            MODE_GET:       w_rd_idx = IDX_W'(r_pos);
            MODE_POP_LAST:  w_rd_idx = IDX_W'(r_count - 1'b1);
            default:        w_rd_idx = '0;
        endcase
    end

    assign w_ctl.sample = (r_state == S_EXEC);
    assign w_ctl.op     = w_apply ? w_op : SH_HOLD;
    assign w_ctl.at     = w_at;
    assign w_ctl.count  = r_count;

    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        t_entry w_prev, w_next;
        if (g == 0) begin : g_first
            assign w_prev = r_new;
        end else begin : g_mid
            assign w_prev = w_cells[g-1];
        end
        if (g == LIST_DEPTH - 1) begin : g_last
            assign w_next = w_cells[g];
        end else begin : g_inner
            assign w_next = w_cells[g+1];
        end
        ile_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_new   (r_new),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_seen  (w_seen[g]),
            .o_seen  (w_seen[g+1]),
            .o_entry (w_cells[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EXEC;
            S_EXEC:  n_state = S_APPLY;
            S_APPLY: if (w_can_load) n_state = w_accept ? S_EXEC : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode      <= i_cmd.mode;
            r_pos       <= i_cmd.position;
            r_new.value <= i_cmd.entry_value;
            r_new.size  <= i_cmd.entry_size;
        end
        if (r_state == S_EXEC) r_rd <= w_cells[w_rd_idx];
        if (w_apply) begin
            r_status  <= n_status;
            r_out     <= n_out;
            r_out_len <= 5'(n_count);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.out_value   = r_out.value;
    assign o_rsp.out_size    = r_out.size;
    assign o_rsp.list_length = r_out_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIST_DEPTH))
        else $error("list length beyond depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted command did not enter compare cycle");

    a_count_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(r_state == S_APPLY))
        else $error("length changed outside apply cycle");

    a_load_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_APPLY))
        else $error("response loaded outside apply cycle");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (o_rsp.status == STAT_EMPTY)) |-> (o_rsp.list_length == 5'd0))
        else $error("empty status with nonzero length");

endmodule
